/* rtl/core/sprf_pkg.sv */
// ============================================================================
// Segment radius point filter: shared package
// Widths, payload types, register indexes and region codes for the capsule
// membership pipeline.
// ============================================================================
package sprf_pkg;

    // Coordinate and radius widths.
    localparam int COORD_BITS    = 24;
    localparam int RADIUS_BITS   = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

    // Differences of two coordinates need one more bit than a coordinate.
    localparam int DIFF_BITS = COORD_BITS + 1;
    // Signed product of two differences.
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    // A sum of three squares stays below 3 * 2^(2*COORD_BITS).
    localparam int SUM_BITS  = 2 * DIFF_BITS;
    localparam int RSQ_BITS  = 2 * RADIUS_BITS;

    // Operands of the wide products are split into two equal halves.
    localparam int OPND_MIN  = (SUM_BITS > RSQ_BITS) ? SUM_BITS : RSQ_BITS;
    localparam int HALF_BITS = (OPND_MIN + 1) / 2;
    localparam int OPND_BITS = 2 * HALF_BITS;
    localparam int WIDE_BITS = 2 * OPND_BITS;

    // Register stages from an accepted item to its result strobe.
    localparam int PIPE_LATENCY = 9;

    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic signed [DIFF_BITS-1:0]   t_diff;
    typedef logic signed [SQ_BITS-1:0]     t_sq;
    typedef logic        [SUM_BITS-1:0]    t_sum;
    typedef logic signed [SUM_BITS:0]      t_c1;
    typedef logic        [RADIUS_BITS-1:0] t_rad;
    typedef logic        [RSQ_BITS-1:0]    t_rsq;
    typedef logic        [HALF_BITS-1:0]   t_half;
    typedef logic        [OPND_BITS-1:0]   t_opnd;
    typedef logic        [2*HALF_BITS-1:0] t_part;
    typedef logic        [2*HALF_BITS:0]   t_mid;
    typedef logic        [WIDE_BITS-1:0]   t_wide;
    typedef logic        [WIDE_BITS:0]     t_wide1;

    localparam t_rad RADIUS_RESET = t_rad'(4000);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_START_Z     = 3'd2,
        CFG_END_X       = 3'd3,
        CFG_END_Y       = 3'd4,
        CFG_END_Z       = 3'd5,
        CFG_KEEP_RADIUS = 3'd6
    } t_cfg_idx;

    // Where the point projects onto the axis.
    typedef enum logic [1:0] {
        REGION_BEFORE = 2'd0,
        REGION_PAST   = 2'd1,
        REGION_BESIDE = 2'd2
    } t_region;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_point;

    typedef struct packed {
        logic    keep;
        t_region region;
        t_coord  out_x;
        t_coord  out_y;
        t_coord  out_z;
    } t_result;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        t_rad   keep_radius;
    } t_cfg;

    // Sideband that travels with an item through the wide compare.
    typedef struct packed {
        t_region region;
        logic    near_keep;
        t_point  point;
    } t_side;

    typedef struct packed {
        t_side side;
        t_sum  ww;
        t_sum  c2;
        t_sum  c1;
        t_rsq  r2;
    } t_front_out;

    typedef struct packed {
        t_side  side;
        t_wide  lhs;
        t_wide1 rhs;
    } t_wide_out;

endpackage

/* rtl/core/sprf_cfg.sv */
// ============================================================================
// Segment radius point filter: configuration registers
// Holds the axis endpoints and the keep radius, written through a plain
// write port. Writes to an index beyond the register list are dropped.
// ============================================================================
module sprf_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [sprf_pkg::CFG_IDX_BITS-1:0]     i_idx,
    input  logic [sprf_pkg::CFG_DATA_BITS-1:0]    i_data,
    output sprf_pkg::t_cfg                        o_cfg
);

    sprf_pkg::t_cfg r_cfg;
    sprf_pkg::t_cfg n_cfg;

    // Decode the index and update one register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                sprf_pkg::CFG_START_X:     n_cfg.start_x = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_START_Y:     n_cfg.start_y = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_START_Z:     n_cfg.start_z = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_END_X:       n_cfg.end_x   = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_END_Y:       n_cfg.end_y   = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_END_Z:       n_cfg.end_z   = i_data[sprf_pkg::COORD_BITS-1:0];
                sprf_pkg::CFG_KEEP_RADIUS: begin
                    n_cfg.keep_radius = i_data[sprf_pkg::RADIUS_BITS-1:0];
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x     <= '0;
            r_cfg.start_y     <= '0;
            r_cfg.start_z     <= '0;
            r_cfg.end_x       <= '0;
            r_cfg.end_y       <= '0;
            r_cfg.end_z       <= '0;
            r_cfg.keep_radius <= sprf_pkg::RADIUS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/sprf_front.sv */
// ============================================================================
// Segment radius point filter: front pipeline
// Four stages: coordinate differences, products, dot-product sums, and the
// region decision with the end-cap distance test.
// ============================================================================
module sprf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  sprf_pkg::t_point       i_point,
    input  sprf_pkg::t_cfg         i_cfg,
    output logic                   o_valid,
    output sprf_pkg::t_front_out   o_data
);

    sprf_pkg::t_coord pt [3];
    sprf_pkg::t_coord st [3];
    sprf_pkg::t_coord en [3];
    sprf_pkg::t_diff  n_s1_w [3];
    sprf_pkg::t_diff  n_s1_v [3];
    sprf_pkg::t_diff  n_s1_e [3];

    logic             r_s1_valid;
    sprf_pkg::t_diff  r_s1_w [3];
    sprf_pkg::t_diff  r_s1_v [3];
    sprf_pkg::t_diff  r_s1_e [3];
    sprf_pkg::t_rad   r_s1_radius;
    sprf_pkg::t_point r_s1_point;

    logic             r_s2_valid;
    sprf_pkg::t_sq    r_s2_ww [3];
    sprf_pkg::t_sq    r_s2_vv [3];
    sprf_pkg::t_sq    r_s2_wv [3];
    sprf_pkg::t_sq    r_s2_ee [3];
    sprf_pkg::t_rsq   r_s2_rr;
    sprf_pkg::t_point r_s2_point;

    logic             r_s3_valid;
    sprf_pkg::t_sum   r_s3_ww;
    sprf_pkg::t_sum   r_s3_c2;
    sprf_pkg::t_sum   r_s3_ee;
    sprf_pkg::t_c1    r_s3_c1;
    sprf_pkg::t_rsq   r_s3_rr;
    sprf_pkg::t_point r_s3_point;

    logic                  r_s4_valid;
    sprf_pkg::t_front_out  r_s4;
    sprf_pkg::t_front_out  n_s4;

    logic              c1_pos;
    sprf_pkg::t_sum    c1_mag;
    logic              ww_in;
    logic              ee_in;
    sprf_pkg::t_region region;

    // Stage 1: offsets from the start point and from the end point.
    always_comb begin
        pt[0] = i_point.point_x;
        pt[1] = i_point.point_y;
        pt[2] = i_point.point_z;
        st[0] = i_cfg.start_x;
        st[1] = i_cfg.start_y;
        st[2] = i_cfg.start_z;
        en[0] = i_cfg.end_x;
        en[1] = i_cfg.end_y;
        en[2] = i_cfg.end_z;
        for (int k = 0; k < 3; k++) begin
            n_s1_w[k] = sprf_pkg::t_diff'(pt[k]) - sprf_pkg::t_diff'(st[k]);
            n_s1_v[k] = sprf_pkg::t_diff'(en[k]) - sprf_pkg::t_diff'(st[k]);
            n_s1_e[k] = sprf_pkg::t_diff'(pt[k]) - sprf_pkg::t_diff'(en[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s1_w[k] <= n_s1_w[k];
            r_s1_v[k] <= n_s1_v[k];
            r_s1_e[k] <= n_s1_e[k];
        end
        r_s1_radius <= i_cfg.keep_radius;
        r_s1_point  <= i_point;
    end

    // Stage 2: one registered product per term.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s2_ww[k] <= sprf_pkg::t_sq'(r_s1_w[k]) * sprf_pkg::t_sq'(r_s1_w[k]);
            r_s2_vv[k] <= sprf_pkg::t_sq'(r_s1_v[k]) * sprf_pkg::t_sq'(r_s1_v[k]);
            r_s2_wv[k] <= sprf_pkg::t_sq'(r_s1_w[k]) * sprf_pkg::t_sq'(r_s1_v[k]);
            r_s2_ee[k] <= sprf_pkg::t_sq'(r_s1_e[k]) * sprf_pkg::t_sq'(r_s1_e[k]);
        end
        r_s2_rr    <= sprf_pkg::t_rsq'(r_s1_radius) * sprf_pkg::t_rsq'(r_s1_radius);
        r_s2_point <= r_s1_point;
    end

    // Stage 3: squared lengths and the signed projection c1.
    always_ff @(posedge i_clk) begin
        r_s3_ww <= sprf_pkg::t_sum'(r_s2_ww[0]) + sprf_pkg::t_sum'(r_s2_ww[1])
                 + sprf_pkg::t_sum'(r_s2_ww[2]);
        r_s3_c2 <= sprf_pkg::t_sum'(r_s2_vv[0]) + sprf_pkg::t_sum'(r_s2_vv[1])
                 + sprf_pkg::t_sum'(r_s2_vv[2]);
        r_s3_ee <= sprf_pkg::t_sum'(r_s2_ee[0]) + sprf_pkg::t_sum'(r_s2_ee[1])
                 + sprf_pkg::t_sum'(r_s2_ee[2]);
        r_s3_c1 <= sprf_pkg::t_c1'(r_s2_wv[0]) + sprf_pkg::t_c1'(r_s2_wv[1])
                 + sprf_pkg::t_c1'(r_s2_wv[2]);
        r_s3_rr    <= r_s2_rr;
        r_s3_point <= r_s2_point;
    end

    // Stage 4: region decision and the distance test at either end.
    always_comb begin
        c1_pos = !r_s3_c1[sprf_pkg::SUM_BITS] && (r_s3_c1 != '0);
        c1_mag = r_s3_c1[sprf_pkg::SUM_BITS-1:0];
        ww_in  = sprf_pkg::t_opnd'(r_s3_ww) <= sprf_pkg::t_opnd'(r_s3_rr);
        ee_in  = sprf_pkg::t_opnd'(r_s3_ee) <= sprf_pkg::t_opnd'(r_s3_rr);
        priority if (!c1_pos) begin
            region = sprf_pkg::REGION_BEFORE;
        end else if (r_s3_c2 <= c1_mag) begin
            region = sprf_pkg::REGION_PAST;
        end else begin
            region = sprf_pkg::REGION_BESIDE;
        end
        n_s4.side.region    = region;
        n_s4.side.near_keep = (region == sprf_pkg::REGION_PAST) ? ee_in : ww_in;
        n_s4.side.point     = r_s3_point;
        n_s4.ww             = r_s3_ww;
        n_s4.c2             = r_s3_c2;
        n_s4.c1             = c1_mag;
        n_s4.r2             = r_s3_rr;
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= n_s4;
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_data  = r_s4;

endmodule

/* rtl/core/sprf_wide.sv */
// ============================================================================
// Segment radius point filter: wide product pipeline
// Forms |w|^2*c2 and r^2*c2 + c1^2 from half-width partial products over
// four stages, for the test beside the span.
// ============================================================================
module sprf_wide (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sprf_pkg::t_front_out  i_data,
    output logic                  o_valid,
    output sprf_pkg::t_wide_out   o_data
);

    sprf_pkg::t_opnd ww_o;
    sprf_pkg::t_opnd c2_o;
    sprf_pkg::t_opnd c1_o;
    sprf_pkg::t_opnd r2_o;
    sprf_pkg::t_half ww_hi, ww_lo, c2_hi, c2_lo, c1_hi, c1_lo, r2_hi, r2_lo;

    logic                r_s5_valid;
    sprf_pkg::t_part     r_s5_a_hh, r_s5_a_hl, r_s5_a_lh, r_s5_a_ll;
    sprf_pkg::t_part     r_s5_b_hh, r_s5_b_hl, r_s5_b_lh, r_s5_b_ll;
    sprf_pkg::t_part     r_s5_c_hh, r_s5_c_hl, r_s5_c_ll;
    sprf_pkg::t_side     r_s5_side;

    logic                r_s6_valid;
    sprf_pkg::t_part     r_s6_a_hh, r_s6_a_ll, r_s6_b_hh, r_s6_b_ll, r_s6_c_hh, r_s6_c_ll;
    sprf_pkg::t_mid      r_s6_a_mid, r_s6_b_mid, r_s6_c_mid;
    sprf_pkg::t_side     r_s6_side;

    logic                r_s7_valid;
    sprf_pkg::t_wide     r_s7_a, r_s7_b, r_s7_c;
    sprf_pkg::t_side     r_s7_side;

    logic                r_s8_valid;
    sprf_pkg::t_wide_out r_s8;

    // Split each operand into upper and lower halves.
    always_comb begin
        ww_o  = sprf_pkg::t_opnd'(i_data.ww);
        c2_o  = sprf_pkg::t_opnd'(i_data.c2);
        c1_o  = sprf_pkg::t_opnd'(i_data.c1);
        r2_o  = sprf_pkg::t_opnd'(i_data.r2);
        ww_hi = ww_o[sprf_pkg::OPND_BITS-1:sprf_pkg::HALF_BITS];
        ww_lo = ww_o[sprf_pkg::HALF_BITS-1:0];
        c2_hi = c2_o[sprf_pkg::OPND_BITS-1:sprf_pkg::HALF_BITS];
        c2_lo = c2_o[sprf_pkg::HALF_BITS-1:0];
        c1_hi = c1_o[sprf_pkg::OPND_BITS-1:sprf_pkg::HALF_BITS];
        c1_lo = c1_o[sprf_pkg::HALF_BITS-1:0];
        r2_hi = r2_o[sprf_pkg::OPND_BITS-1:sprf_pkg::HALF_BITS];
        r2_lo = r2_o[sprf_pkg::HALF_BITS-1:0];
    end

    // Stage 5: half-width partial products, each registered.
    always_ff @(posedge i_clk) begin
        r_s5_a_hh <= sprf_pkg::t_part'(ww_hi) * sprf_pkg::t_part'(c2_hi);
        r_s5_a_hl <= sprf_pkg::t_part'(ww_hi) * sprf_pkg::t_part'(c2_lo);
        r_s5_a_lh <= sprf_pkg::t_part'(ww_lo) * sprf_pkg::t_part'(c2_hi);
        r_s5_a_ll <= sprf_pkg::t_part'(ww_lo) * sprf_pkg::t_part'(c2_lo);
        r_s5_b_hh <= sprf_pkg::t_part'(r2_hi) * sprf_pkg::t_part'(c2_hi);
        r_s5_b_hl <= sprf_pkg::t_part'(r2_hi) * sprf_pkg::t_part'(c2_lo);
        r_s5_b_lh <= sprf_pkg::t_part'(r2_lo) * sprf_pkg::t_part'(c2_hi);
        r_s5_b_ll <= sprf_pkg::t_part'(r2_lo) * sprf_pkg::t_part'(c2_lo);
        r_s5_c_hh <= sprf_pkg::t_part'(c1_hi) * sprf_pkg::t_part'(c1_hi);
        r_s5_c_hl <= sprf_pkg::t_part'(c1_hi) * sprf_pkg::t_part'(c1_lo);
        r_s5_c_ll <= sprf_pkg::t_part'(c1_lo) * sprf_pkg::t_part'(c1_lo);
        r_s5_side <= i_data.side;
    end

    // Stage 6: add the two cross terms of each product.
    always_ff @(posedge i_clk) begin
        r_s6_a_mid <= sprf_pkg::t_mid'(r_s5_a_hl) + sprf_pkg::t_mid'(r_s5_a_lh);
        r_s6_b_mid <= sprf_pkg::t_mid'(r_s5_b_hl) + sprf_pkg::t_mid'(r_s5_b_lh);
        r_s6_c_mid <= {r_s5_c_hl, 1'b0};
        r_s6_a_hh  <= r_s5_a_hh;
        r_s6_a_ll  <= r_s5_a_ll;
        r_s6_b_hh  <= r_s5_b_hh;
        r_s6_b_ll  <= r_s5_b_ll;
        r_s6_c_hh  <= r_s5_c_hh;
        r_s6_c_ll  <= r_s5_c_ll;
        r_s6_side  <= r_s5_side;
    end

    // Stage 7: outer terms sit side by side; one add places the cross terms.
    always_ff @(posedge i_clk) begin
        r_s7_a <= sprf_pkg::t_wide'({r_s6_a_hh, r_s6_a_ll})
                + (sprf_pkg::t_wide'(r_s6_a_mid) << sprf_pkg::HALF_BITS);
        r_s7_b <= sprf_pkg::t_wide'({r_s6_b_hh, r_s6_b_ll})
                + (sprf_pkg::t_wide'(r_s6_b_mid) << sprf_pkg::HALF_BITS);
        r_s7_c <= sprf_pkg::t_wide'({r_s6_c_hh, r_s6_c_ll})
                + (sprf_pkg::t_wide'(r_s6_c_mid) << sprf_pkg::HALF_BITS);
        r_s7_side <= r_s6_side;
    end

    // Stage 8: right-hand side of the test beside the span.
    always_ff @(posedge i_clk) begin
        r_s8.side <= r_s7_side;
        r_s8.lhs  <= r_s7_a;
        r_s8.rhs  <= sprf_pkg::t_wide1'(r_s7_b) + sprf_pkg::t_wide1'(r_s7_c);
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
        end else begin
            r_s5_valid <= i_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
            r_s8_valid <= r_s7_valid;
        end
    end

    assign o_valid = r_s8_valid;
    assign o_data  = r_s8;

endmodule

/* rtl/core/segment_radius_point_filter.sv */
// ============================================================================
// Segment radius point filter: top level
// Tests each 3-D point against a capsule around a configured axis segment
// and reports the keep flag, the region and the point itself.
// ============================================================================
//
//  Channel   Ports                                  Transfer
//  -------   -----------------------------------    ---------------------------
//  point     i_start, o_busy, i_point               i_start high, o_busy low
//  result    o_strobe, o_result                     o_strobe high, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data        i_cfg_we high
//
//  One point is taken every cycle while o_busy is low; each result passes
//  through the nine register stages of the pipeline (the wide products are
//  built from half-width partial products over four of them).
//  Reset is synchronous and active low: it clears every valid bit, returns
//  the configuration registers to their reset values and holds o_busy high.
//  Results cannot be held off, so the pipeline never stalls.
//
module segment_radius_point_filter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  sprf_pkg::t_point                      i_point,
    output logic                                  o_strobe,
    output sprf_pkg::t_result                     o_result,
    input  logic                                  i_cfg_we,
    input  logic [sprf_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [sprf_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    sprf_pkg::t_cfg        cfg;
    logic                  front_valid;
    sprf_pkg::t_front_out  front_data;
    logic                  wide_valid;
    sprf_pkg::t_wide_out   wide_data;
    logic                  accept;
    logic                  beside_keep;

    logic                  r_busy;
    logic                  r_strobe;
    sprf_pkg::t_result     r_result;
    sprf_pkg::t_result     n_result;

    // Busy only while in reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign accept = i_start && !r_busy;

    sprf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sprf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_point (i_point),
        .i_cfg   (cfg),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    sprf_wide u_wide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (wide_valid),
        .o_data  (wide_data)
    );

    // Stage 9: final compare and choice of the keep flag.
    always_comb begin
        beside_keep       = sprf_pkg::t_wide1'(wide_data.lhs) <= wide_data.rhs;
        n_result.region   = wide_data.side.region;
        n_result.keep     = (wide_data.side.region == sprf_pkg::REGION_BESIDE) ?
                            beside_keep : wide_data.side.near_keep;
        n_result.out_x    = wide_data.side.point.point_x;
        n_result.out_y    = wide_data.side.point.point_y;
        n_result.out_z    = wide_data.side.point.point_z;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= wide_valid;
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* rtl/core/sprf_checker.sv */
// ============================================================================
// Segment radius point filter: port checker
// Watches the top level's ports for fixed latency, point pass-through,
// unsolicited results and readiness after reset.
// ============================================================================
module sprf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                o_busy,
    input  sprf_pkg::t_point    i_point,
    input  logic                o_strobe,
    input  sprf_pkg::t_result   o_result
);

    localparam int LAT = sprf_pkg::PIPE_LATENCY;

    // Every transfer in gives a result a fixed number of cycles later.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_strobe)
        else $error("result strobe missing after a point transfer");

    // The point comes back unchanged with its own result.
    a_pass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT
        ((o_result.out_x == $past(i_point.point_x, LAT)) &&
         (o_result.out_y == $past(i_point.point_y, LAT)) &&
         (o_result.out_z == $past(i_point.point_z, LAT))))
        else $error("result point differs from the transferred point");

    // No result appears without a transfer in.
    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, LAT)) |-> $past(i_start && !o_busy, LAT))
        else $error("result strobe without a matching point transfer");

    // Once out of reset the block can take a point in every cycle.
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy raised outside reset");

endmodule

bind segment_radius_point_filter sprf_checker u_sprf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_point  (i_point),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
